[rtl/ptw_pkg.sv]
package ptw_pkg;

  // Field widths of the walker's ports
  localparam int unsigned VIRT_BITS = 48;
  localparam int unsigned PHYS_BITS = 52;
  localparam int unsigned ADDR_W    = 52;
  localparam int unsigned ENTRY_W   = 64;
  localparam int unsigned IDX_W     = 9;
  localparam int unsigned LEVEL_W   = 2;
  localparam int unsigned PAGE_OFS_W = 12;
  localparam int unsigned HUGE_OFS_W = 21;

  // Address masks; only bits below PHYS_BITS take part in a physical address
  localparam logic [ADDR_W-1:0] PHYS_MASK       = ADDR_W'((65'd1 << PHYS_BITS) - 65'd1);
  localparam logic [ADDR_W-1:0] FRAME_MASK      = PHYS_MASK & ~ADDR_W'(12'hFFF);
  localparam logic [ADDR_W-1:0] HUGE_FRAME_MASK = PHYS_MASK & ~ADDR_W'(21'h1FFFFF);

  // Entry flag positions
  localparam int unsigned BIT_PRESENT = 0;
  localparam int unsigned BIT_HUGE    = 7;

  // Walk levels
  localparam logic [LEVEL_W-1:0] LEVEL_TOP  = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_DIR  = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_LEAF = 2'd3;

  // Input commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_RESP  = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_FAULT = 2'd2;

  // Source of the result address
  typedef enum logic [2:0] {
    ASEL_ROOT,
    ASEL_NEXT,
    ASEL_LEAF,
    ASEL_HUGE,
    ASEL_ZERO
  } addr_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic               load_virt;
    logic               load_out;
    logic [1:0]         kind;
    addr_sel_t          addr_sel;
    logic [LEVEL_W-1:0] idx_level;
  } ptw_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic present;
    logic huge;
  } ptw_stat_t;

endpackage

[rtl/ptw_ctrl.sv]
module ptw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_command,
  input  logic              out_ready,
  input  ptw_pkg::ptw_stat_t stat,
  output logic              in_ready,
  output logic              out_valid,
  output ptw_pkg::ptw_cmd_t cmd
);
  import ptw_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               acc;
  logic               emit;

  // An item is taken whenever the output register is free or being drained
  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign acc       = in_valid && in_ready;

  // Walk sequencing: decide the next level and what the datapath produces
  always_comb begin
    state_nxt     = state_r;
    level_nxt     = level_r;
    emit          = 1'b0;
    cmd.load_virt = 1'b0;
    cmd.kind      = KIND_READ;
    cmd.addr_sel  = ASEL_ZERO;
    cmd.idx_level = level_r + 2'd1;
    if (acc) begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_command == CMD_START) begin
            emit          = 1'b1;
            cmd.load_virt = 1'b1;
            cmd.kind      = KIND_READ;
            cmd.addr_sel  = ASEL_ROOT;
            cmd.idx_level = LEVEL_TOP;
            level_nxt     = LEVEL_TOP;
            state_nxt     = ST_WALK;
          end
        end
        ST_WALK: begin
          if (in_command == CMD_RESP) begin
            emit = 1'b1;
            if (level_r == LEVEL_LEAF) begin
              cmd.kind     = KIND_DONE;
              cmd.addr_sel = ASEL_LEAF;
              level_nxt    = LEVEL_TOP;
              state_nxt    = ST_IDLE;
            end else if (level_r == LEVEL_DIR && stat.huge) begin
              cmd.kind     = KIND_DONE;
              cmd.addr_sel = ASEL_HUGE;
              level_nxt    = LEVEL_TOP;
              state_nxt    = ST_IDLE;
            end else if (!stat.present) begin
              cmd.kind     = KIND_FAULT;
              cmd.addr_sel = ASEL_ZERO;
              level_nxt    = LEVEL_TOP;
              state_nxt    = ST_IDLE;
            end else begin
              cmd.kind     = KIND_READ;
              cmd.addr_sel = ASEL_NEXT;
              level_nxt    = level_r + 2'd1;
            end
          end
        end
        default: begin
          state_nxt = ST_IDLE;
          level_nxt = LEVEL_TOP;
        end
      endcase
    end
    cmd.load_out  = emit;
    out_valid_nxt = emit || (out_valid_r && !out_ready);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      level_r     <= LEVEL_TOP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The state register always holds exactly one state.
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("walker state is not one-hot");

  // An idle walker always sits at the top level.
  a_idle_top: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (level_r == LEVEL_TOP))
    else $error("idle walker is not at the top level");

  // An ignored item leaves no result behind.
  a_ignored_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !emit) |=> !out_valid_r)
    else $error("ignored item left a result pending");

  // A leaf response always finishes the walk.
  a_leaf_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && state_r == ST_WALK && in_command == CMD_RESP && level_r == LEVEL_LEAF)
    |=> (state_r == ST_IDLE && out_valid_r))
    else $error("leaf response did not finish the walk");

endmodule

[rtl/ptw_dp.sv]
module ptw_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ptw_pkg::ADDR_W-1:0]    cfg_wdata,
  input  logic [ptw_pkg::VIRT_BITS-1:0] in_virt_addr,
  input  logic [ptw_pkg::ENTRY_W-1:0]   in_entry_data,
  input  ptw_pkg::ptw_cmd_t             cmd,
  output ptw_pkg::ptw_stat_t            stat,
  output logic [1:0]                    out_kind,
  output logic [ptw_pkg::ADDR_W-1:0]    out_address
);
  import ptw_pkg::*;

  logic [ADDR_W-1:0]    root_r;
  logic [VIRT_BITS-1:0] saved_virt_r;
  logic [1:0]           out_kind_r;
  logic [ADDR_W-1:0]    out_addr_r;
  logic [VIRT_BITS-1:0] idx_src;
  logic [IDX_W-1:0]     idx;
  logic [ADDR_W-1:0]    idx_ofs;
  logic [ADDR_W-1:0]    entry_addr;
  logic [ADDR_W-1:0]    addr_nxt;

  // Entry flags for the controller
  assign stat.present = in_entry_data[BIT_PRESENT];
  assign stat.huge    = in_entry_data[BIT_HUGE];

  // Table index: a new walk takes it from the incoming address
  assign idx_src    = cmd.load_virt ? in_virt_addr : saved_virt_r;
  assign entry_addr = in_entry_data[ADDR_W-1:0];

  always_comb begin
    case (cmd.idx_level)
      2'd0:    idx = idx_src[47:39];
      2'd1:    idx = idx_src[38:30];
      2'd2:    idx = idx_src[29:21];
      default: idx = idx_src[20:12];
    endcase
  end

  assign idx_ofs = {{(ADDR_W-IDX_W-3){1'b0}}, idx, 3'b000};

  // Result address for each outcome of a step
  always_comb begin
    unique case (cmd.addr_sel)
      ASEL_ROOT: addr_nxt = (root_r & FRAME_MASK) | idx_ofs;
      ASEL_NEXT: addr_nxt = (entry_addr & FRAME_MASK) | idx_ofs;
      ASEL_LEAF: addr_nxt = (entry_addr & FRAME_MASK)
                          | {{(ADDR_W-PAGE_OFS_W){1'b0}}, saved_virt_r[PAGE_OFS_W-1:0]};
      ASEL_HUGE: addr_nxt = (entry_addr & HUGE_FRAME_MASK)
                          | {{(ADDR_W-HUGE_OFS_W){1'b0}}, saved_virt_r[HUGE_OFS_W-1:0]};
      default:   addr_nxt = '0;
    endcase
  end

  // Root table register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
    end else if (cfg_we) begin
      root_r <= cfg_wdata;
    end
  end

  // Saved address and output payload
  always_ff @(posedge clk) begin
    if (cmd.load_virt) begin
      saved_virt_r <= in_virt_addr;
    end
    if (cmd.load_out) begin
      out_kind_r <= cmd.kind;
      out_addr_r <= addr_nxt & PHYS_MASK;
    end
  end

  assign out_kind    = out_kind_r;
  assign out_address = out_addr_r;

endmodule

[rtl/page_table_walker.sv]
// A result item is in the output register the cycle after its item is taken.
// Throughput: one item per cycle unless stalled; a walk is one start and up to four responses.
// An item is taken whenever the output register is empty or drained in the same cycle.
// Reset (synchronous, active low) clears the root table address, returns the walker to
// idle at the top level and empties the output register.
module page_table_walker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ptw_pkg::ADDR_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic [ptw_pkg::VIRT_BITS-1:0] in_virt_addr,
  input  logic [ptw_pkg::ENTRY_W-1:0]   in_entry_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [ptw_pkg::ADDR_W-1:0]    out_address
);
  import ptw_pkg::*;

  ptw_cmd_t  cmd;
  ptw_stat_t stat;

  // Walk controller
  ptw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .out_ready  (out_ready),
    .stat       (stat),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .cmd        (cmd)
  );

  // Address datapath
  ptw_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_virt_addr  (in_virt_addr),
    .in_entry_data (in_entry_data),
    .cmd           (cmd),
    .stat          (stat),
    .out_kind      (out_kind),
    .out_address   (out_address)
  );

endmodule
